>>> rtl/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared types, opcodes and sizes for the tiny CPU instruction executor.
// ----------------------------------------------------------------------------
package tcpu_pkg;

  localparam int XLEN        = 32;
  localparam int IN_W        = 32;
  localparam int OUT_W       = 72;  // 69 payload bits padded to whole bytes
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_REGS    = 4;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);

  // Return stack depth; must be a power of two so the slot is a bit-select.
  localparam int STACK_DEPTH = 256;
  localparam int SLOT_W      = $clog2(STACK_DEPTH);

  typedef logic [XLEN-1:0]   word_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // Opcodes
  localparam logic [7:0] OP_MOV  = 8'h01;
  localparam logic [7:0] OP_ADD  = 8'h10;
  localparam logic [7:0] OP_CALL = 8'h32;
  localparam logic [7:0] OP_RET  = 8'h33;
  localparam logic [7:0] OP_HLT  = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_PC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SP = 2'd1;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_HLT = 2'd1,
    ST_BAD = 2'd2,
    ST_IGN = 2'd3
  } status_t;

  // Result beat, lowest field last
  typedef struct packed {
    logic [2:0]           pad;
    word_t                reg_value;
    logic [REG_IDX_W-1:0] reg_index;
    logic                 reg_written;
    status_t              status;
    word_t                next_pc;
  } result_t;

  // Word slot of a byte stack pointer, wrapping over the stack depth
  function automatic slot_t slot_of(word_t sp);
    return sp[SLOT_W+1:2];
  endfunction

endpackage

>>> rtl/tcpu_ram.sv
// ----------------------------------------------------------------------------
// tcpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/tiny_cpu_instruction_execute.sv
// ----------------------------------------------------------------------------
// tiny_cpu_instruction_execute
// Executes one instruction word per beat: MOV, ADD, CALL, RET, HLT on a
// four-register machine with a RAM-backed return stack; other opcodes halt.
// Result beat is registered: it is valid the cycle after the instruction beat is taken.
// One instruction per cycle while the output is not stalled; the stack RAM read for
// RET is issued from the slot of the next stack pointer and registered, with a bypass for a fresh CALL.
// Reset (synchronous, rst_n low): PC, SP, registers cleared, not halted,
// all stack entries read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module tiny_cpu_instruction_execute (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: instr[31:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcpu_pkg::IN_W-1:0]       in_tdata,
  // out_tdata: next_pc[31:0], status[33:32], reg_written[34],
  //            reg_index[36:35], reg_value[68:37], zero pad[71:69]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcpu_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [tcpu_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tcpu_pkg::CFG_W-1:0]      cfg_wdata
);

  import tcpu_pkg::*;

  // Architectural state
  word_t                  pc_r, pc_nxt;
  word_t                  sp_r, sp_nxt;
  word_t                  regs_r [NUM_REGS];
  word_t                  regs_nxt [NUM_REGS];
  logic                   halted_r, halted_nxt;

  // Return stack
  logic [STACK_DEPTH-1:0] stk_vld_r;
  logic                   stk_we;
  slot_t                  stk_waddr;
  slot_t                  stk_raddr;
  word_t                  stk_rdata;
  logic                   stk_ent_vld_r;
  logic                   stk_hit_r;
  word_t                  stk_hit_data_r;
  word_t                  tos;

  // Output stage
  logic                   out_valid_r;
  result_t                out_data_r;
  result_t                res;

  // Decode
  logic                   in_acc;
  logic [7:0]             op;
  logic [7:0]             b1;
  word_t                  pc_after;
  logic [REG_IDX_W-1:0]   src_idx;
  logic [REG_IDX_W-1:0]   dst_idx;
  word_t                  sum;

  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  assign op       = in_tdata[31:24];
  assign b1       = in_tdata[23:16];
  assign pc_after = pc_r + word_t'(4);
  assign src_idx  = b1[5:4];
  assign dst_idx  = b1[1:0];
  assign sum      = regs_r[dst_idx] + regs_r[src_idx];

  // Top of stack: fresh CALL bypass, else RAM entry if ever written
  assign tos = stk_hit_r ? stk_hit_data_r : (stk_ent_vld_r ? stk_rdata : '0);

  always_comb begin
    pc_nxt      = pc_r;
    sp_nxt      = sp_r;
    halted_nxt  = halted_r;
    for (int i = 0; i < NUM_REGS; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    stk_we      = 1'b0;
    res         = '0;
    res.status  = ST_RUN;

    if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_START_PC: pc_nxt = cfg_wdata;
        CFG_START_SP: sp_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (in_acc) begin
      if (halted_r) begin
        res.status = ST_IGN;
      end else begin
        pc_nxt = pc_after;
        case (op)
          OP_MOV: begin
            if (b1[7:2] == '0) begin
              regs_nxt[b1[1:0]] = {16'b0, in_tdata[15:0]};
              res.reg_written   = 1'b1;
              res.reg_index     = b1[1:0];
              res.reg_value     = {16'b0, in_tdata[15:0]};
            end
          end
          OP_ADD: begin
            if (b1[7:6] == '0 && b1[3:2] == '0) begin
              regs_nxt[dst_idx] = sum;
              res.reg_written   = 1'b1;
              res.reg_index     = dst_idx;
              res.reg_value     = sum;
            end
          end
          OP_CALL: begin
            sp_nxt = sp_r - word_t'(4);
            stk_we = 1'b1;
            pc_nxt = {8'b0, in_tdata[23:0]};
          end
          OP_RET: begin
            pc_nxt = tos;
            sp_nxt = sp_r + word_t'(4);
          end
          OP_HLT: begin
            halted_nxt = 1'b1;
            res.status = ST_HLT;
          end
          default: begin
            halted_nxt = 1'b1;
            res.status = ST_BAD;
          end
        endcase
      end
    end
    res.next_pc = pc_nxt;
  end

  assign stk_waddr = slot_of(sp_nxt);
  // Read the slot the next stack pointer names so RET sees it next cycle
  assign stk_raddr = rst_n ? slot_of(sp_nxt) : '0;

  tcpu_ram #(
    .WIDTH (XLEN),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (pc_after),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= '0;
      sp_r          <= '0;
      halted_r      <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
      stk_vld_r     <= '0;
      stk_ent_vld_r <= 1'b0;
      stk_hit_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      pc_r          <= pc_nxt;
      sp_r          <= sp_nxt;
      halted_r      <= halted_nxt;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
      if (stk_we) begin
        stk_vld_r[stk_waddr] <= 1'b1;
      end
      stk_ent_vld_r <= stk_vld_r[stk_raddr];
      stk_hit_r     <= stk_we && (stk_waddr == stk_raddr);
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stk_hit_data_r <= pc_after;
    if (in_acc) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_call_tos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !halted_r && op == OP_CALL && !cfg_wr_en |=> tos == $past(pc_after))
    else $error("top of stack does not hold return address after CALL");

  a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && !cfg_wr_en |=> $stable(pc_r) && halted_r)
    else $error("PC moved while halted");

  a_ignored_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && halted_r |=> out_data_r.status == ST_IGN && !out_data_r.reg_written)
    else $error("instruction while halted not reported as ignored");

  a_stop_sets_halt: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !halted_r && (res.status == ST_HLT || res.status == ST_BAD) |=> halted_r)
    else $error("HLT or unknown opcode did not halt");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.reg_written |->
      out_data_r.reg_index == '0 && out_data_r.reg_value == '0)
    else $error("register fields set without a register write");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the tiny CPU instruction executor. Instruction beats
// go in with random bursts and gaps, and result beats come out against a
// random ready pattern. A scoreboard runs its own model of PC, SP,
// registers and return stack, and checks every result field in order.
// Directed corner cases run first, then random programs run under several
// start PC / start SP settings. The run halts the machine only at the very
// end, since halting is sticky until reset.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
  localparam int                   RX_HOLD_CYCLES = 300;
  localparam int                   PHASE_ITEMS    = 250;

  // PC starts two words below the wrap point so the first beats cross it
  localparam word_t START_PC_WRAP = 32'hFFFF_FFF8;

  localparam word_t DIRECTED_PROG [18] = '{
    {OP_MOV,  8'h00, 16'hFFFF},
    {OP_MOV,  8'h01, 16'h8001},
    {OP_MOV,  8'h02, 16'h0000},
    {OP_MOV,  8'h03, 16'hA5A5},
    {OP_MOV,  8'h04, 16'h1234},   // index out of range
    {OP_MOV,  8'hFF, 16'hFFFF},   // index out of range
    {OP_ADD,  8'h00, 16'hFFFF},
    {OP_ADD,  8'h00, 16'h0000},
    {OP_ADD,  8'h13, 16'h5A5A},
    {OP_ADD,  8'h32, 16'h0000},
    {OP_ADD,  8'h40, 16'h0000},   // bad source nibble
    {OP_ADD,  8'h0F, 16'h0000},   // bad destination nibble
    {OP_ADD,  8'hFF, 16'hFFFF},
    {OP_CALL, 24'hFF_FFFF},       // SP wraps below zero
    {OP_CALL, 24'h00_0000},
    {OP_RET,  24'hFF_FFFF},
    {OP_RET,  24'h00_0000},
    {OP_RET,  24'h5A_5A5A}        // pops an entry never pushed
  };

  class exec_scoreboard;
    word_t   pc;
    word_t   sp;
    word_t   regs [NUM_REGS];
    word_t   ret_stack [STACK_DEPTH];
    bit      halted;
    result_t expected_results [$];
    int      errors;

    function new();
      pc     = '0;
      sp     = '0;
      halted = 1'b0;
      errors = 0;
      foreach (regs[i]) regs[i] = '0;
      foreach (ret_stack[i]) ret_stack[i] = '0;
    endfunction

    function slot_t slot_for(word_t p);
      word_t w;
      w = (p >> 2) % word_t'(STACK_DEPTH);
      return slot_t'(w);
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, word_t value);
      case (idx)
        CFG_START_PC: pc = value;
        CFG_START_SP: sp = value;
        default: ;
      endcase
    endfunction

    function void take_instr(word_t instr);
      result_t    r;
      logic [7:0] op;
      logic [7:0] b1;
      logic [3:0] src;
      logic [3:0] dst;
      word_t      ret_pc;
      r   = '0;
      op  = instr[31:24];
      b1  = instr[23:16];
      src = b1[7:4];
      dst = b1[3:0];
      if (halted) begin
        r.status = ST_IGN;
      end else begin
        ret_pc   = pc + 32'd4;
        pc       = ret_pc;
        r.status = ST_RUN;
        case (op)
          OP_MOV: begin
            if (b1 < NUM_REGS) begin
              regs[b1[1:0]] = {16'h0000, instr[15:0]};
              r.reg_written = 1'b1;
              r.reg_index   = b1[1:0];
              r.reg_value   = regs[b1[1:0]];
            end
          end
          OP_ADD: begin
            if (src < NUM_REGS && dst < NUM_REGS) begin
              regs[dst[1:0]] = regs[dst[1:0]] + regs[src[1:0]];
              r.reg_written  = 1'b1;
              r.reg_index    = dst[1:0];
              r.reg_value    = regs[dst[1:0]];
            end
          end
          OP_CALL: begin
            sp = sp - 32'd4;
            ret_stack[slot_for(sp)] = ret_pc;
            pc = {8'h00, instr[23:0]};
          end
          OP_RET: begin
            pc = ret_stack[slot_for(sp)];
            sp = sp + 32'd4;
          end
          OP_HLT: begin
            halted   = 1'b1;
            r.status = ST_HLT;
          end
          default: begin
            halted   = 1'b1;
            r.status = ST_BAD;
          end
        endcase
      end
      r.next_pc = pc;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, word_t want, word_t got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      result_t got;
      result_t want;
      got = result_t'(beat);
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing pending: expected none, actual %h",
                 $time, beat);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("status", word_t'(want.status), word_t'(got.status));
      compare_field("reg_written", word_t'(want.reg_written), word_t'(got.reg_written));
      compare_field("reg_index", word_t'(want.reg_index), word_t'(got.reg_index));
      compare_field("reg_value", want.reg_value, got.reg_value);
      compare_field("pad", word_t'(want.pad), word_t'(got.pad));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;   // instr[31:0]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;  // next_pc, status, reg_written, reg_index, reg_value, pad
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  exec_scoreboard sb;
  int             hold_reqs = 0;

  tiny_cpu_instruction_execute u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.take_instr(in_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  // Receiver: ready pattern changes mode every so often; a hold request
  // drops ready for a long stretch so the block backs up into its input.
  initial begin
    int mode;
    int left;
    int holds_done;
    out_tready = 1'b0;
    mode       = 0;
    left       = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_reqs) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic word_t random_instr(int call_pct, int ret_pct);
    int         pick;
    logic [7:0] b1;
    pick = $urandom_range(0, 99);
    if (pick < call_pct) return {OP_CALL, 24'($urandom)};
    if (pick < call_pct + ret_pct) return {OP_RET, 24'($urandom)};
    if ($urandom_range(0, 1) == 0) begin
      b1 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 255))
                                       : 8'($urandom_range(0, 3));
      return {OP_MOV, b1, 16'($urandom)};
    end
    // both nibbles in range most of the time
    b1 = 8'($urandom);
    if ($urandom_range(0, 9) != 0) b1 = b1 & 8'h33;
    return {OP_ADD, b1, 16'($urandom)};
  endfunction

  task automatic send_instr(input word_t instr);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= instr;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_run(input int count, input int call_pct, input int ret_pct,
                          input int max_gap);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_instr(random_instr(call_pct, ret_pct));
      left -= burst;
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Stop sending and wait for every pending result beat
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input word_t value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.configure(idx, value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    word_t      pc_cfg;
    word_t      sp_cfg;
    word_t      halt_word;
    logic [7:0] bad_op;
    int         call_pct;
    int         ret_pct;
    int         max_gap;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(CFG_START_PC, START_PC_WRAP);
    cfg_write(CFG_START_SP, '0);
    for (int i = 0; i < 18; i++) send_instr(DIRECTED_PROG[i]);

    for (int ph = 1; ph <= 7; ph++) begin
      drain();
      case ($urandom_range(0, 3))
        0: pc_cfg = '0;
        1: pc_cfg = 32'hFFFF_FFFC;
        2: pc_cfg = {8'h00, 24'($urandom)};
        default: pc_cfg = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: sp_cfg = '0;
        1: sp_cfg = 32'h0000_0400;   // exactly one lap of the stack
        2: sp_cfg = 32'($urandom_range(0, 7));
        default: sp_cfg = $urandom;
      endcase
      if (ph == 1) begin
        pc_cfg = '1;
        sp_cfg = '1;
      end
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(CFG_START_PC, pc_cfg);
        cfg_write(CFG_START_SP, sp_cfg);
      end else begin
        cfg_write(CFG_START_SP, sp_cfg);
        cfg_write(CFG_START_PC, pc_cfg);
      end
      if ($urandom_range(0, 2) == 0) cfg_write(CFG_UNUSED, $urandom);

      case (ph % 3)
        0: begin call_pct = 15; ret_pct = 15; end
        1: begin call_pct = 25; ret_pct = 8;  end
        default: begin call_pct = 8; ret_pct = 25; end
      endcase
      max_gap = (ph % 2 == 1) ? 8 : 3;
      if (ph == 3 || ph == 5) max_gap = 0;
      if (ph == 3) hold_reqs++;
      send_run(PHASE_ITEMS, call_pct, ret_pct, max_gap);
    end

    // Halting is sticky, so it comes last; every later beat is ignored
    drain();
    if ($urandom_range(0, 1) == 0) begin
      halt_word = {OP_HLT, 24'($urandom)};
    end else begin
      do bad_op = 8'($urandom) | 8'hCC; while (bad_op == OP_HLT);
      halt_word = {bad_op, 24'($urandom)};
    end
    send_instr(halt_word);
    repeat (30) send_instr($urandom);
    drain();
    // a PC load while halted shows up in the held next_pc
    cfg_write(CFG_START_PC, $urandom);
    cfg_write(CFG_START_SP, $urandom);
    repeat (10) send_instr($urandom);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
